FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker modules.
// Each macro expects signals named clk and rst_n in the enclosing scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACTR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("checker: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define ACTR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker: next-cycle property failed");

`endif

FILE: hw/rtl/actr_pkg.sv
// ----------------------------------------------------------------------------
// actr_pkg
// Types, tables and round functions for the AES-256 CTR random bit generator.
// ----------------------------------------------------------------------------
package actr_pkg;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_KEXP,
        ST_LOAD,
        ST_ROUND,
        ST_DONE
    } state_t;

    localparam int unsigned LAST_ROUND = 14;
    localparam int unsigned SEED_LAST  = 5;

    // AES forward substitution table.
    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    // Multiply by x in GF(2^8) modulo 0x11b.
    function automatic logic [7:0] xtime(input logic [7:0] a);
        return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Substitute the four bytes of a key schedule word.
    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
    endfunction

    // One AES-256 key schedule step: the next round key from the two before it.
    function automatic logic [127:0] key_step(input logic [255:0] kw, input logic [3:0] r);
        logic [31:0] last;
        logic [31:0] t;
        logic [7:0]  rcon;
        logic [31:0] w0, w1, w2, w3;
        last = kw[31:0];
        rcon = 8'h01 << (r[3:1] - 3'd1);
        if (!r[0])
        begin
            t = sub_word({last[23:0], last[31:24]}) ^ {rcon, 24'h000000};
        end
        else
        begin
            t = sub_word(last);
        end
        w0 = kw[255:224] ^ t;
        w1 = kw[223:192] ^ w0;
        w2 = kw[191:160] ^ w1;
        w3 = kw[159:128] ^ w2;
        return {w0, w1, w2, w3};
    endfunction

    // One AES encryption round; the last round skips the column mix.
    function automatic logic [127:0] aes_round(input logic [127:0] s,
                                               input logic [127:0] rk,
                                               input logic         last);
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [7:0]   all;
        logic [127:0] res;
        int c, i;
        for (c = 0; c < 4; c++)
        begin
            for (i = 0; i < 4; i++)
            begin
                t[i + 4 * c] = SBOX[s[127 - 8 * (i + 4 * ((c + i) & 3)) -: 8]];
            end
        end
        for (c = 0; c < 4; c++)
        begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (i = 0; i < 16; i++)
        begin
            res[127 - 8 * i -: 8] = (last ? t[i] : m[i]) ^ rk[127 - 8 * i -: 8];
        end
        return res;
    endfunction

endpackage

FILE: hw/rtl/actr_cmd_if.sv
// ----------------------------------------------------------------------------
// actr_cmd_if
// Command channel: seed word loads and generate requests.
// ----------------------------------------------------------------------------
interface actr_cmd_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [63:0] seed_word;
    logic [63:0] personal_word;
    logic [2:0]  seed_index;
    logic [10:0] request_bytes;

    modport source (output valid, kind, seed_word, personal_word, seed_index,
                    request_bytes, input ready);
    modport sink   (input valid, kind, seed_word, personal_word, seed_index,
                    request_bytes, output ready);
endinterface

FILE: hw/rtl/actr_blk_if.sv
// ----------------------------------------------------------------------------
// actr_blk_if
// Output channel: one 16-byte random block per beat.
// ----------------------------------------------------------------------------
interface actr_blk_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_upper;
    logic [63:0] block_lower;
    logic [4:0]  valid_bytes;
    logic        last_block;
    logic [47:0] generate_count;

    modport source (output valid, block_upper, block_lower, valid_bytes, last_block,
                    generate_count, input ready);
    modport sink   (input valid, block_upper, block_lower, valid_bytes, last_block,
                    generate_count, output ready);
endinterface

FILE: hw/rtl/aes256_ctr_drbg_generator.sv
// ----------------------------------------------------------------------------
// aes256_ctr_drbg_generator
// AES-256 counter-mode random bit generator without derivation function.
// ----------------------------------------------------------------------------
// Usage:
// - cmd carries seed word loads (kind 0) and generate requests (kind 1).
//   Six seed words at indices 0 to 5 form the seed; index 5 instantiates.
// - blk returns one 16-byte block per beat; the final block of a request
//   carries last_block and may hold fewer than 16 valid bytes.
// - cmd.ready is high only while the sequencer is idle. A seed word at
//   indices 0 to 4 (or 6, 7, which are ignored) leaves the sequencer idle.
// - Instantiation and each generate request first expand the key, one round
//   key a cycle. Each AES block then runs on the single shared round unit:
//   a load state, a round state per AES round and a finish state.
// - A generate request of N blocks runs N output blocks and then three
//   update blocks; instantiation runs only the three update blocks.
// - A finished block waits in the output register; if the receiver stalls,
//   the sequencer holds the next finished block until the register drains.
// - Reset clears key, counter and stored request count to zero.
// ----------------------------------------------------------------------------
module aes256_ctr_drbg_generator #(
    parameter int unsigned MAX_REQUEST_BLOCKS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    actr_cmd_if.sink   cmd,
    actr_blk_if.source blk
);

    localparam logic [10:0] MaxBytes = 11'(MAX_REQUEST_BLOCKS * 16);

    actr_pkg::state_t state_reg, state_next;

    logic [255:0] key_reg,     key_next;
    logic [127:0] ctr_reg,     ctr_next;
    logic [47:0]  req_cnt_reg, req_cnt_next;
    logic [47:0]  gen_cnt_reg, gen_cnt_next;
    logic [255:0] kw_reg,      kw_next;
    logic [3:0]   kround_reg,  kround_next;
    logic [3:0]   round_reg,   round_next;
    logic [127:0] aes_reg,     aes_next;
    logic [10:0]  bytes_reg,   bytes_next;
    logic         is_gen_reg,  is_gen_next;
    logic         phase_reg,   phase_next;
    logic [1:0]   upd_reg,     upd_next;
    logic [255:0] temp_reg,    temp_next;

    logic         ov_reg,      ov_next;
    logic [127:0] ob_reg,      ob_next;
    logic [4:0]   obytes_reg,  obytes_next;
    logic         olast_reg,   olast_next;
    logic [47:0]  ocnt_reg,    ocnt_next;

    logic [127:0] rk_mem   [15];
    logic [63:0]  seed_mem [6];

    logic         rk_we;
    logic [127:0] rk_wdata;
    logic         seed_we;
    logic [2:0]   seed_addr;
    logic [127:0] rk_rd;
    logic [383:0] material;
    logic [383:0] upd_data;
    logic [4:0]   blk_bytes;
    logic [127:0] blk_mask;
    logic         out_free;

    assign rk_rd    = rk_mem[round_reg];
    assign material = {seed_mem[0], seed_mem[1], seed_mem[2],
                       seed_mem[3], seed_mem[4], seed_mem[5]};
    assign upd_data = {temp_reg, aes_reg} ^ (is_gen_reg ? 384'd0 : material);
    assign out_free = !ov_reg || blk.ready;

    // Bytes in the current block and the mask that zeroes the rest.
    always_comb
    begin
        blk_bytes = (bytes_reg >= 11'd16) ? 5'd16 : 5'(bytes_reg);
        for (int k = 0; k < 16; k++)
        begin
            blk_mask[127 - 8 * k -: 8] = (5'(k) < blk_bytes) ? 8'hff : 8'h00;
        end
    end

    // Sequencer: next state and datapath controls.
    always_comb
    begin
        state_next   = state_reg;
        key_next     = key_reg;
        ctr_next     = ctr_reg;
        req_cnt_next = req_cnt_reg;
        gen_cnt_next = gen_cnt_reg;
        kw_next      = kw_reg;
        kround_next  = kround_reg;
        round_next   = round_reg;
        aes_next     = aes_reg;
        bytes_next   = bytes_reg;
        is_gen_next  = is_gen_reg;
        phase_next   = phase_reg;
        upd_next     = upd_reg;
        temp_next    = temp_reg;
        ov_next      = blk.ready ? 1'b0 : ov_reg;
        ob_next      = ob_reg;
        obytes_next  = obytes_reg;
        olast_next   = olast_reg;
        ocnt_next    = ocnt_reg;
        rk_we        = 1'b0;
        rk_wdata     = actr_pkg::key_step(kw_reg, kround_reg);
        seed_we      = 1'b0;
        seed_addr    = cmd.seed_index;
        cmd.ready    = (state_reg == actr_pkg::ST_IDLE);

        unique case (state_reg)
            actr_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    kround_next = 4'd0;
                    if (!cmd.kind)
                    begin
                        seed_we = (cmd.seed_index <= 3'(actr_pkg::SEED_LAST));
                        if (cmd.seed_index == 3'(actr_pkg::SEED_LAST))
                        begin
                            key_next    = '0;
                            ctr_next    = 128'd1;
                            kw_next     = '0;
                            is_gen_next = 1'b0;
                            state_next  = actr_pkg::ST_KEXP;
                        end
                    end
                    else
                    begin
                        bytes_next   = (cmd.request_bytes > MaxBytes) ? MaxBytes
                                                                      : cmd.request_bytes;
                        gen_cnt_next = req_cnt_reg + 48'd1;
                        kw_next      = key_reg;
                        is_gen_next  = 1'b1;
                        state_next   = actr_pkg::ST_KEXP;
                    end
                end
            end

            actr_pkg::ST_KEXP:
            begin
                rk_we = 1'b1;
                if (kround_reg == 4'd0)
                begin
                    rk_wdata = kw_reg[255:128];
                end
                else if (kround_reg == 4'd1)
                begin
                    rk_wdata = kw_reg[127:0];
                end
                else
                begin
                    kw_next = {kw_reg[127:0], rk_wdata};
                end
                if (kround_reg == 4'(actr_pkg::LAST_ROUND))
                begin
                    round_next = 4'd0;
                    upd_next   = 2'd0;
                    phase_next = is_gen_reg && (bytes_reg != 11'd0);
                    state_next = actr_pkg::ST_LOAD;
                end
                else
                begin
                    kround_next = kround_reg + 4'd1;
                end
            end

            actr_pkg::ST_LOAD:
            begin
                aes_next   = ctr_reg ^ rk_rd;
                ctr_next   = ctr_reg + 128'd1;
                round_next = 4'd1;
                state_next = actr_pkg::ST_ROUND;
            end

            actr_pkg::ST_ROUND:
            begin
                aes_next = actr_pkg::aes_round(aes_reg, rk_rd,
                                               round_reg == 4'(actr_pkg::LAST_ROUND));
                if (round_reg == 4'(actr_pkg::LAST_ROUND))
                begin
                    state_next = actr_pkg::ST_DONE;
                end
                else
                begin
                    round_next = round_reg + 4'd1;
                end
            end

            actr_pkg::ST_DONE:
            begin
                if (phase_reg)
                begin
                    // Hand a generated block to the output register.
                    if (out_free)
                    begin
                        ov_next     = 1'b1;
                        ob_next     = aes_reg & blk_mask;
                        obytes_next = blk_bytes;
                        olast_next  = (bytes_reg <= 11'd16);
                        ocnt_next   = gen_cnt_reg;
                        bytes_next  = bytes_reg - 11'(blk_bytes);
                        phase_next  = (bytes_reg > 11'd16);
                        round_next  = 4'd0;
                        state_next  = actr_pkg::ST_LOAD;
                    end
                end
                else if (upd_reg == 2'd2)
                begin
                    // Third update block: install new key and counter.
                    key_next     = upd_data[383:128];
                    ctr_next     = upd_data[127:0] + 128'd1;
                    req_cnt_next = is_gen_reg ? gen_cnt_reg : 48'd1;
                    state_next   = actr_pkg::ST_IDLE;
                end
                else
                begin
                    temp_next  = {temp_reg[127:0], aes_reg};
                    upd_next   = upd_reg + 2'd1;
                    round_next = 4'd0;
                    state_next = actr_pkg::ST_LOAD;
                end
            end

            default:
            begin
                state_next = actr_pkg::ST_IDLE;
            end
        endcase
    end

    // Control and state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= actr_pkg::ST_IDLE;
            key_reg     <= '0;
            ctr_reg     <= '0;
            req_cnt_reg <= '0;
            kround_reg  <= '0;
            round_reg   <= '0;
            is_gen_reg  <= 1'b0;
            phase_reg   <= 1'b0;
            upd_reg     <= '0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            key_reg     <= key_next;
            ctr_reg     <= ctr_next;
            req_cnt_reg <= req_cnt_next;
            kround_reg  <= kround_next;
            round_reg   <= round_next;
            is_gen_reg  <= is_gen_next;
            phase_reg   <= phase_next;
            upd_reg     <= upd_next;
            ov_reg      <= ov_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        gen_cnt_reg <= gen_cnt_next;
        kw_reg      <= kw_next;
        aes_reg     <= aes_next;
        bytes_reg   <= bytes_next;
        temp_reg    <= temp_next;
        ob_reg      <= ob_next;
        obytes_reg  <= obytes_next;
        olast_reg   <= olast_next;
        ocnt_reg    <= ocnt_next;
    end

    // Round key and seed word stores.
    always_ff @(posedge clk)
    begin
        if (rk_we)
        begin
            rk_mem[kround_reg] <= rk_wdata;
        end
        if (seed_we)
        begin
            seed_mem[seed_addr] <= cmd.seed_word ^ cmd.personal_word;
        end
    end

    // Output channel.
    assign blk.valid          = ov_reg;
    assign blk.block_upper    = ob_reg[127:64];
    assign blk.block_lower    = ob_reg[63:0];
    assign blk.valid_bytes    = obytes_reg;
    assign blk.last_block     = olast_reg;
    assign blk.generate_count = ocnt_reg;

endmodule

FILE: hw/rtl/actr_checker.sv
// ----------------------------------------------------------------------------
// actr_checker
// Port-level checks on the output channel of the random bit generator.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module actr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [4:0]  valid_bytes,
    input logic        last_block,
    input logic [47:0] generate_count
);

    // A stalled beat stays offered.
    `ACTR_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid)
    // A block always carries one to sixteen bytes.
    `ACTR_ASSERT_SAME(a_bytes, out_valid, valid_bytes != 5'd0 && valid_bytes <= 5'd16)
    // Only the final block of a request may be partial.
    `ACTR_ASSERT_SAME(a_full, out_valid && !last_block, valid_bytes == 5'd16)
    // The reported generate count is never zero on the first wrap-free run.
    `ACTR_ASSERT_SAME(a_count, out_valid && !(&generate_count), generate_count != 48'd0)

endmodule

bind aes256_ctr_drbg_generator actr_checker u_actr_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (blk.valid),
    .out_ready      (blk.ready),
    .valid_bytes    (blk.valid_bytes),
    .last_block     (blk.last_block),
    .generate_count (blk.generate_count)
);
